@@ rtl/vrp_pkg.sv @@
// Types and constants shared by the vertex rotate and project pipeline.
package vrp_pkg;

   localparam int COORD_BITS          = 16;
   localparam int COEF_BITS           = 16;
   localparam int COEF_FRAC_BITS      = 14;
   localparam int MATRIX_DIM          = 3;
   localparam int ROW_BITS            = MATRIX_DIM * COEF_BITS;
   localparam int FOCAL               = 5000;
   localparam int CENTER_X            = 640;
   localparam int BASE_Y              = 720;

   localparam int PROD_BITS           = COORD_BITS + COEF_BITS;
   localparam int OFFSET_SCALED_BITS  = COORD_BITS + COEF_FRAC_BITS;
   localparam int ACC_BITS            = ((PROD_BITS + 2 > OFFSET_SCALED_BITS) ?
                                         PROD_BITS + 2 : OFFSET_SCALED_BITS) + 2;
   localparam int NUM_BITS            = ACC_BITS + 15;
   localparam int QUOT_BITS           = COORD_BITS + 1;
   localparam int DIV_BITS            = ACC_BITS + QUOT_BITS;
   localparam int SAT_BITS            = QUOT_BITS + 1;

   localparam logic signed [ACC_BITS-1:0] FOCAL_SCALED =
      ACC_BITS'(FOCAL) <<< COEF_FRAC_BITS;

   localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   localparam logic [ROW_BITS-1:0] ROW0_RESET =
      ROW_BITS'(1) << (2 * COEF_BITS + COEF_FRAC_BITS);
   localparam logic [ROW_BITS-1:0] ROW1_RESET =
      ROW_BITS'(1) << (COEF_BITS + COEF_FRAC_BITS);
   localparam logic [ROW_BITS-1:0] ROW2_RESET =
      ROW_BITS'(1) << COEF_FRAC_BITS;

   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MATRIX_ROW0 = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MATRIX_ROW1 = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MATRIX_ROW2 = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OFFSET_X    = CSR_INDEX_BITS'(3);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OFFSET_Y    = CSR_INDEX_BITS'(4);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OFFSET_Z    = CSR_INDEX_BITS'(5);

   typedef struct packed {
      logic signed [COORD_BITS-1:0] vertex_x;
      logic signed [COORD_BITS-1:0] vertex_y;
      logic signed [COORD_BITS-1:0] vertex_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] screen_x;
      logic signed [COORD_BITS-1:0] screen_y;
      logic                         behind_camera;
   } rsp_type;

   typedef struct packed {
      logic        [ROW_BITS-1:0]   matrix_row0;
      logic        [ROW_BITS-1:0]   matrix_row1;
      logic        [ROW_BITS-1:0]   matrix_row2;
      logic signed [COORD_BITS-1:0] offset_x;
      logic signed [COORD_BITS-1:0] offset_y;
      logic signed [COORD_BITS-1:0] offset_z;
   } csr_type;

   typedef struct packed {
      logic signed [ACC_BITS-1:0] xr;
      logic signed [ACC_BITS-1:0] yr;
      logic signed [ACC_BITS-1:0] depth;
   } xform_type;

   typedef struct packed {
      logic [NUM_BITS-1:0] mag_x;
      logic [NUM_BITS-1:0] mag_y;
      logic [ACC_BITS-1:0] depth;
      logic                neg_x;
      logic                neg_y;
      logic                ovf_x;
      logic                ovf_y;
      logic                behind;
   } num_type;

   typedef struct packed {
      logic [DIV_BITS-1:0]  rem_x;
      logic [DIV_BITS-1:0]  rem_y;
      logic [QUOT_BITS-1:0] quot_x;
      logic [QUOT_BITS-1:0] quot_y;
      logic [ACC_BITS-1:0]  depth;
      logic                 neg_x;
      logic                 neg_y;
      logic                 ovf_x;
      logic                 ovf_y;
      logic                 behind;
   } div_type;

endpackage

@@ rtl/vertex_rotate_project.sv @@
// Vertex rotate and perspective project: top level with registers and output stage.
//
// Input transfers on req_valid/req_ready carry one model-space vertex (req_payload).
// Each vertex is rotated by the 3x3 Q1.14 matrix, translated by the camera offset
// and projected through a pinhole of focal length 5000 around column 640, row 720.
// Each vertex gives exactly one result on rsp_valid/rsp_ready: the screen column
// and row, truncated toward zero and saturated to 16 bits, or zeros with
// behind_camera set when depth plus focal length is zero or less.
// Registers are written on csr_valid/csr_ready; csr_ready is always high.
// Indexes: 0..2 matrix rows, 3..5 offsets x, y, z; other indexes are ignored.
// Write registers only while no vertex is in flight.
// Stages in order: the rotation, the numerators and range check, the divider
// (one quotient bit per stage) and the output register.
// Throughput is one vertex per cycle while the receiver does not stall.
// Reset is synchronous: the pipeline empties and the registers return to the
// identity matrix and zero offsets.
// When the receiver stalls, each stage holds as soon as the one after it is full;
// bubbles still close up and input is taken until every stage holds a vertex.
module vertex_rotate_project (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  vrp_pkg::req_type                       req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output vrp_pkg::rsp_type                       rsp_payload,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [vrp_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [vrp_pkg::ROW_BITS-1:0]           csr_data
);

   vrp_pkg::csr_type   csr_ff, csr_in;
   vrp_pkg::xform_type xform_data;
   vrp_pkg::num_type   num_data;
   vrp_pkg::div_type   div_data;
   vrp_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff;
   logic               xform_valid, xform_ready;
   logic               num_valid, num_ready;
   logic               div_valid, div_ready;

   function automatic logic signed [vrp_pkg::COORD_BITS-1:0] sat_coord(
      input logic [vrp_pkg::QUOT_BITS-1:0] quot,
      input logic                          neg,
      input logic                          ovf
   );
      logic signed [vrp_pkg::SAT_BITS-1:0]   val;
      logic signed [vrp_pkg::COORD_BITS-1:0] res;
      val = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
      if (ovf) begin
         res = neg ? vrp_pkg::COORD_MIN : vrp_pkg::COORD_MAX;
      end else if (val > vrp_pkg::SAT_BITS'(vrp_pkg::COORD_MAX)) begin
         res = vrp_pkg::COORD_MAX;
      end else if (val < vrp_pkg::SAT_BITS'(vrp_pkg::COORD_MIN)) begin
         res = vrp_pkg::COORD_MIN;
      end else begin
         res = vrp_pkg::COORD_BITS'(val);
      end
      return res;
   endfunction

   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         case (csr_index)
            vrp_pkg::CSR_MATRIX_ROW0: csr_in.matrix_row0 = csr_data;
            vrp_pkg::CSR_MATRIX_ROW1: csr_in.matrix_row1 = csr_data;
            vrp_pkg::CSR_MATRIX_ROW2: csr_in.matrix_row2 = csr_data;
            vrp_pkg::CSR_OFFSET_X:    csr_in.offset_x = csr_data[vrp_pkg::COORD_BITS-1:0];
            vrp_pkg::CSR_OFFSET_Y:    csr_in.offset_y = csr_data[vrp_pkg::COORD_BITS-1:0];
            vrp_pkg::CSR_OFFSET_Z:    csr_in.offset_z = csr_data[vrp_pkg::COORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.matrix_row0 <= vrp_pkg::ROW0_RESET;
         csr_ff.matrix_row1 <= vrp_pkg::ROW1_RESET;
         csr_ff.matrix_row2 <= vrp_pkg::ROW2_RESET;
         csr_ff.offset_x    <= '0;
         csr_ff.offset_y    <= '0;
         csr_ff.offset_z    <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   vrp_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_payload),
      .out_valid (xform_valid),
      .out_ready (xform_ready),
      .out_data  (xform_data)
   );

   vrp_numer u_numer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (xform_valid),
      .in_ready  (xform_ready),
      .in_data   (xform_data),
      .out_valid (num_valid),
      .out_ready (num_ready),
      .out_data  (num_data)
   );

   vrp_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (num_valid),
      .in_ready  (num_ready),
      .in_data   (num_data),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   assign div_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_in.behind_camera = div_data.behind;
      if (div_data.behind) begin
         rsp_in.screen_x = '0;
         rsp_in.screen_y = '0;
      end else begin
         rsp_in.screen_x = sat_coord(div_data.quot_x, div_data.neg_x, div_data.ovf_x);
         rsp_in.screen_y = sat_coord(div_data.quot_y, div_data.neg_y, div_data.ovf_y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (div_ready) begin
         rsp_valid_ff <= div_valid;
      end
      if (div_ready) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("result valid after reset");

   a_behind_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.behind_camera) |->
         (rsp_ff.screen_x == '0 && rsp_ff.screen_y == '0))
      else $error("behind-camera result with non-zero coordinates");

   a_ready_when_empty: assert property (@(posedge clock)
      !rsp_valid_ff |-> req_ready)
      else $error("input stalled with output register empty");

endmodule

@@ rtl/vrp_xform.sv @@
// Rotation by the coefficient matrix and camera translation, two stages.
module vrp_xform (
   input  logic                clock,
   input  logic                reset,
   input  vrp_pkg::csr_type    csr,
   input  logic                in_valid,
   output logic                in_ready,
   input  vrp_pkg::req_type    in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output vrp_pkg::xform_type  out_data
);

   localparam int NPROD = vrp_pkg::MATRIX_DIM * vrp_pkg::MATRIX_DIM;

   logic signed [vrp_pkg::PROD_BITS-1:0]  prod_ff [NPROD];
   logic signed [vrp_pkg::PROD_BITS-1:0]  prod_in [NPROD];
   logic                                  valid_a_ff;
   logic                                  valid_b_ff;
   logic                                  ready_a;
   logic                                  ready_b;
   vrp_pkg::xform_type                    xform_ff;
   vrp_pkg::xform_type                    xform_in;
   logic signed [vrp_pkg::COORD_BITS-1:0] vert [vrp_pkg::MATRIX_DIM];
   logic        [vrp_pkg::ROW_BITS-1:0]   rows [vrp_pkg::MATRIX_DIM];
   logic signed [vrp_pkg::ACC_BITS-1:0]   acc  [vrp_pkg::MATRIX_DIM];

   assign ready_b   = !valid_b_ff || out_ready;
   assign ready_a   = !valid_a_ff || ready_b;
   assign in_ready  = ready_a;
   assign out_valid = valid_b_ff;
   assign out_data  = xform_ff;

   always_comb begin
      vert[0] = in_data.vertex_x;
      vert[1] = in_data.vertex_y;
      vert[2] = in_data.vertex_z;
      rows[0] = csr.matrix_row0;
      rows[1] = csr.matrix_row1;
      rows[2] = csr.matrix_row2;
      for (int r = 0; r < vrp_pkg::MATRIX_DIM; r++) begin
         for (int c = 0; c < vrp_pkg::MATRIX_DIM; c++) begin
            prod_in[r*vrp_pkg::MATRIX_DIM+c] =
               $signed(rows[r][vrp_pkg::ROW_BITS-1-c*vrp_pkg::COEF_BITS -: vrp_pkg::COEF_BITS])
               * vert[c];
         end
      end
   end

   always_comb begin
      for (int r = 0; r < vrp_pkg::MATRIX_DIM; r++) begin
         acc[r] = vrp_pkg::ACC_BITS'(prod_ff[r*vrp_pkg::MATRIX_DIM])
                + vrp_pkg::ACC_BITS'(prod_ff[r*vrp_pkg::MATRIX_DIM+1])
                + vrp_pkg::ACC_BITS'(prod_ff[r*vrp_pkg::MATRIX_DIM+2]);
      end
      xform_in.xr    = acc[0]
                     - (vrp_pkg::ACC_BITS'(csr.offset_x) <<< vrp_pkg::COEF_FRAC_BITS);
      xform_in.yr    = acc[1]
                     + (vrp_pkg::ACC_BITS'(csr.offset_y) <<< vrp_pkg::COEF_FRAC_BITS);
      xform_in.depth = acc[2]
                     + (vrp_pkg::ACC_BITS'(csr.offset_z) <<< vrp_pkg::COEF_FRAC_BITS)
                     + vrp_pkg::FOCAL_SCALED;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         if (ready_a) valid_a_ff <= in_valid;
         if (ready_b) valid_b_ff <= valid_a_ff;
      end
      if (ready_a) prod_ff  <= prod_in;
      if (ready_b) xform_ff <= xform_in;
   end

endmodule

@@ rtl/vrp_numer.sv @@
// Projection numerators, magnitudes and quotient range check, three stages.
module vrp_numer (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  vrp_pkg::xform_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output vrp_pkg::num_type    out_data
);

   typedef struct packed {
      logic signed [vrp_pkg::NUM_BITS-1:0] nx;
      logic signed [vrp_pkg::NUM_BITS-1:0] ny;
      logic        [vrp_pkg::ACC_BITS-1:0] depth;
      logic                                behind;
   } prod_stage_type;

   prod_stage_type   c_ff, c_in;
   vrp_pkg::num_type d_ff, d_in, e_ff, e_in;
   logic             valid_c_ff, valid_d_ff, valid_e_ff;
   logic             ready_c, ready_d, ready_e;

   assign ready_e   = !valid_e_ff || out_ready;
   assign ready_d   = !valid_d_ff || ready_e;
   assign ready_c   = !valid_c_ff || ready_d;
   assign in_ready  = ready_c;
   assign out_valid = valid_e_ff;
   assign out_data  = e_ff;

   always_comb begin
      c_in.nx = vrp_pkg::NUM_BITS'(in_data.depth) * vrp_pkg::NUM_BITS'(vrp_pkg::CENTER_X)
              + vrp_pkg::NUM_BITS'(in_data.xr) * vrp_pkg::NUM_BITS'(vrp_pkg::FOCAL);
      c_in.ny = vrp_pkg::NUM_BITS'(in_data.depth) * vrp_pkg::NUM_BITS'(vrp_pkg::BASE_Y)
              - vrp_pkg::NUM_BITS'(in_data.yr) * vrp_pkg::NUM_BITS'(vrp_pkg::FOCAL);
      c_in.depth  = in_data.depth;
      c_in.behind = (in_data.depth <= 0);
   end

   always_comb begin
      d_in        = '0;
      d_in.neg_x  = c_ff.nx[vrp_pkg::NUM_BITS-1];
      d_in.neg_y  = c_ff.ny[vrp_pkg::NUM_BITS-1];
      d_in.mag_x  = d_in.neg_x ? vrp_pkg::NUM_BITS'(-c_ff.nx) : c_ff.nx;
      d_in.mag_y  = d_in.neg_y ? vrp_pkg::NUM_BITS'(-c_ff.ny) : c_ff.ny;
      d_in.depth  = c_ff.depth;
      d_in.behind = c_ff.behind;
   end

   always_comb begin
      e_in       = d_ff;
      e_in.ovf_x = vrp_pkg::DIV_BITS'(d_ff.mag_x)
                   >= (vrp_pkg::DIV_BITS'(d_ff.depth) << vrp_pkg::QUOT_BITS);
      e_in.ovf_y = vrp_pkg::DIV_BITS'(d_ff.mag_y)
                   >= (vrp_pkg::DIV_BITS'(d_ff.depth) << vrp_pkg::QUOT_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_c_ff <= 1'b0;
         valid_d_ff <= 1'b0;
         valid_e_ff <= 1'b0;
      end else begin
         if (ready_c) valid_c_ff <= in_valid;
         if (ready_d) valid_d_ff <= valid_c_ff;
         if (ready_e) valid_e_ff <= valid_d_ff;
      end
      if (ready_c) c_ff <= c_in;
      if (ready_d) d_ff <= d_in;
      if (ready_e) e_ff <= e_in;
   end

endmodule

@@ rtl/vrp_divide.sv @@
// Pipelined restoring divider, one quotient bit of each coordinate per stage.
module vrp_divide (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  vrp_pkg::num_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output vrp_pkg::div_type  out_data
);

   localparam int NSTAGE = vrp_pkg::QUOT_BITS;

   vrp_pkg::div_type     stage_ff [NSTAGE];
   vrp_pkg::div_type     stage_in [NSTAGE];
   vrp_pkg::div_type     src      [NSTAGE];
   vrp_pkg::div_type     entry;
   logic [NSTAGE-1:0]    valid_ff;
   logic [NSTAGE-1:0]    src_valid;
   logic [NSTAGE:0]      ready;
   logic [vrp_pkg::DIV_BITS-1:0] divisor [NSTAGE];

   always_comb begin
      entry        = '0;
      entry.rem_x  = vrp_pkg::DIV_BITS'(in_data.mag_x);
      entry.rem_y  = vrp_pkg::DIV_BITS'(in_data.mag_y);
      entry.depth  = in_data.depth;
      entry.neg_x  = in_data.neg_x;
      entry.neg_y  = in_data.neg_y;
      entry.ovf_x  = in_data.ovf_x;
      entry.ovf_y  = in_data.ovf_y;
      entry.behind = in_data.behind;
   end

   always_comb begin
      ready[NSTAGE] = out_ready;
      for (int i = NSTAGE - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   assign src_valid = {valid_ff[NSTAGE-2:0], in_valid};
   assign in_ready  = ready[0];
   assign out_valid = valid_ff[NSTAGE-1];
   assign out_data  = stage_ff[NSTAGE-1];

   always_comb begin
      src[0] = entry;
      for (int i = 1; i < NSTAGE; i++) begin
         src[i] = stage_ff[i-1];
      end
      for (int i = 0; i < NSTAGE; i++) begin
         stage_in[i] = src[i];
         divisor[i]  = vrp_pkg::DIV_BITS'(src[i].depth) << (NSTAGE - 1 - i);
         if (src[i].rem_x >= divisor[i]) begin
            stage_in[i].rem_x  = src[i].rem_x - divisor[i];
            stage_in[i].quot_x = src[i].quot_x
                               | (vrp_pkg::QUOT_BITS'(1) << (NSTAGE - 1 - i));
         end
         if (src[i].rem_y >= divisor[i]) begin
            stage_in[i].rem_y  = src[i].rem_y - divisor[i];
            stage_in[i].quot_y = src[i].quot_y
                               | (vrp_pkg::QUOT_BITS'(1) << (NSTAGE - 1 - i));
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NSTAGE; i++) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (ready[i]) begin
            valid_ff[i] <= src_valid[i];
         end
         if (ready[i]) stage_ff[i] <= stage_in[i];
      end
   end

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the vertex rotate and perspective project pipeline.
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int PHASE_ITEMS    = 300;

   localparam logic [vrp_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_LO = vrp_pkg::CSR_INDEX_BITS'(6);
   localparam logic [vrp_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_HI = vrp_pkg::CSR_INDEX_BITS'(7);

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   vrp_pkg::req_type                   req_payload = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   vrp_pkg::rsp_type                   rsp_payload;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [vrp_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [vrp_pkg::ROW_BITS-1:0]       csr_data = '0;

   vrp_pkg::req_type vertex_queue[$];
   vrp_pkg::rsp_type screen_expect[$];

   logic [vrp_pkg::ROW_BITS-1:0]   matrix_row[3];
   logic [vrp_pkg::COORD_BITS-1:0] cam_offset[3];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int error_count = 0;
   int vertices_sent = 0;
   int screens_seen = 0;
   int behind_seen = 0;
   int quiet_cycles = 0;

   vertex_rotate_project dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic longint coef_of(logic [vrp_pkg::ROW_BITS-1:0] row, int slot);
      logic signed [vrp_pkg::COEF_BITS-1:0] c;
      c = row[vrp_pkg::ROW_BITS-1-slot*vrp_pkg::COEF_BITS -: vrp_pkg::COEF_BITS];
      return longint'(c);
   endfunction

   function automatic longint rotate_row(int r, vrp_pkg::req_type v);
      return coef_of(matrix_row[r], 0) * longint'(v.vertex_x)
           + coef_of(matrix_row[r], 1) * longint'(v.vertex_y)
           + coef_of(matrix_row[r], 2) * longint'(v.vertex_z);
   endfunction

   function automatic logic [vrp_pkg::COORD_BITS-1:0] clamp_coord(longint q);
      if (q > longint'(vrp_pkg::COORD_MAX)) return vrp_pkg::COORD_MAX;
      if (q < longint'(vrp_pkg::COORD_MIN)) return vrp_pkg::COORD_MIN;
      return q[vrp_pkg::COORD_BITS-1:0];
   endfunction

   function automatic vrp_pkg::rsp_type project_vertex(vrp_pkg::req_type v);
      longint           scale, xr, yr, zr, depth;
      vrp_pkg::rsp_type r;
      scale = longint'(1) <<< vrp_pkg::COEF_FRAC_BITS;
      xr = rotate_row(0, v) - longint'($signed(cam_offset[0])) * scale;
      yr = rotate_row(1, v) + longint'($signed(cam_offset[1])) * scale;
      zr = rotate_row(2, v) + longint'($signed(cam_offset[2])) * scale;
      depth = zr + longint'(vrp_pkg::FOCAL) * scale;
      r = '0;
      if (depth <= 0) begin
         r.behind_camera = 1'b1;
      end else begin
         r.screen_x = clamp_coord((longint'(vrp_pkg::CENTER_X) * depth
                                   + xr * vrp_pkg::FOCAL) / depth);
         r.screen_y = clamp_coord((longint'(vrp_pkg::BASE_Y) * depth
                                   - yr * vrp_pkg::FOCAL) / depth);
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // driver: predict on transfer, then present the next vertex or idle
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            screen_expect.push_back(project_vertex(req_payload));
            vertices_sent++;
         end
         if (!req_valid || req_ready) begin
            if (vertex_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_payload <= vertex_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rspc_check();
      rsp_ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic rspc_check();
      vrp_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         screens_seen++;
         if (rsp_payload.behind_camera) behind_seen++;
         if (screen_expect.size() == 0) begin
            report_mismatch("unexpected result, screen_x", rsp_payload.screen_x, 0);
         end else begin
            want = screen_expect.pop_front();
            if (rsp_payload.screen_x !== want.screen_x)
               report_mismatch("screen_x", rsp_payload.screen_x, want.screen_x);
            if (rsp_payload.screen_y !== want.screen_y)
               report_mismatch("screen_y", rsp_payload.screen_y, want.screen_y);
            if (rsp_payload.behind_camera !== want.behind_camera)
               report_mismatch("behind_camera", rsp_payload.behind_camera,
                               want.behind_camera);
         end
      end
   endtask

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", screen_expect.size());
            $display("[vertex_rotate_project] ERROR");
            $finish;
         end
      end
   end

   task automatic csr_write(logic [vrp_pkg::CSR_INDEX_BITS-1:0] idx,
                            logic [vrp_pkg::ROW_BITS-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         vrp_pkg::CSR_MATRIX_ROW0: matrix_row[0] = data;
         vrp_pkg::CSR_MATRIX_ROW1: matrix_row[1] = data;
         vrp_pkg::CSR_MATRIX_ROW2: matrix_row[2] = data;
         vrp_pkg::CSR_OFFSET_X:    cam_offset[0] = data[vrp_pkg::COORD_BITS-1:0];
         vrp_pkg::CSR_OFFSET_Y:    cam_offset[1] = data[vrp_pkg::COORD_BITS-1:0];
         vrp_pkg::CSR_OFFSET_Z:    cam_offset[2] = data[vrp_pkg::COORD_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (vertex_queue.size() > 0 || req_valid || screen_expect.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [vrp_pkg::COEF_BITS-1:0] rand_coef();
      if ($urandom_range(2) == 0) return vrp_pkg::COEF_BITS'($urandom());
      return vrp_pkg::COEF_BITS'($urandom_range(32768) - 16384);
   endfunction

   function automatic logic [vrp_pkg::ROW_BITS-1:0] rand_row();
      logic [vrp_pkg::ROW_BITS-1:0] row;
      row = {rand_coef(), rand_coef(), rand_coef()};
      return row;
   endfunction

   function automatic vrp_pkg::req_type rand_vertex();
      vrp_pkg::req_type v;
      case ($urandom_range(3))
         0: begin
            v.vertex_x = vrp_pkg::COORD_BITS'($urandom());
            v.vertex_y = vrp_pkg::COORD_BITS'($urandom());
            v.vertex_z = vrp_pkg::COORD_BITS'($urandom());
         end
         1: begin
            v.vertex_x = vrp_pkg::COORD_BITS'($urandom_range(8000) - 4000);
            v.vertex_y = vrp_pkg::COORD_BITS'($urandom_range(8000) - 4000);
            v.vertex_z = vrp_pkg::COORD_BITS'($urandom_range(8000) - 4000);
         end
         2: begin
            v.vertex_x = vrp_pkg::COORD_BITS'($urandom_range(600) - 300);
            v.vertex_y = vrp_pkg::COORD_BITS'($urandom_range(600) - 300);
            v.vertex_z = vrp_pkg::COORD_BITS'($urandom_range(200) - 5100);
         end
         default: begin
            v.vertex_x = vrp_pkg::COORD_BITS'($urandom());
            v.vertex_y = vrp_pkg::COORD_BITS'($urandom());
            v.vertex_z = vrp_pkg::COORD_BITS'($urandom_range(600) - 5300);
         end
      endcase
      return v;
   endfunction

   task automatic load_random(int count);
      repeat (count) vertex_queue.push_back(rand_vertex());
   endtask

   function automatic vrp_pkg::req_type vtx(int x, int y, int z);
      vrp_pkg::req_type v;
      v.vertex_x = vrp_pkg::COORD_BITS'(x);
      v.vertex_y = vrp_pkg::COORD_BITS'(y);
      v.vertex_z = vrp_pkg::COORD_BITS'(z);
      return v;
   endfunction

   initial begin
      matrix_row[0] = vrp_pkg::ROW0_RESET;
      matrix_row[1] = vrp_pkg::ROW1_RESET;
      matrix_row[2] = vrp_pkg::ROW2_RESET;
      cam_offset[0] = '0;
      cam_offset[1] = '0;
      cam_offset[2] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed, reset matrix
      vertex_queue.push_back(vtx(0, 0, 0));
      vertex_queue.push_back(vtx(32767, 32767, 32767));
      vertex_queue.push_back(vtx(-32768, -32768, -32768));
      vertex_queue.push_back(vtx(32767, -32768, 0));
      vertex_queue.push_back(vtx(-32768, 32767, 0));
      vertex_queue.push_back(vtx(100, 100, -5000));
      vertex_queue.push_back(vtx(100, 100, -4999));
      vertex_queue.push_back(vtx(-100, -100, -4999));
      vertex_queue.push_back(vtx(32767, 32767, -4999));
      vertex_queue.push_back(vtx(-32768, -32768, -4999));
      vertex_queue.push_back(vtx(5, 7, -32768));
      vertex_queue.push_back(vtx(-3, 9, -4990));
      vertex_queue.push_back(vtx(1234, -4321, 2000));
      wait_drained();

      // extreme matrices and offsets
      csr_write(vrp_pkg::CSR_MATRIX_ROW0, {3{16'h8000}});
      csr_write(vrp_pkg::CSR_MATRIX_ROW1, {3{16'h7fff}});
      csr_write(vrp_pkg::CSR_MATRIX_ROW2, {16'h0000, 16'h0000, 16'h8000});
      csr_write(vrp_pkg::CSR_OFFSET_X, 48'hffff_ffff_8000);
      csr_write(vrp_pkg::CSR_OFFSET_Y, 48'h0000_0000_7fff);
      csr_write(vrp_pkg::CSR_OFFSET_Z, 48'h0000_0000_8000);
      csr_write(CSR_SPARE_LO, '1);
      csr_write(CSR_SPARE_HI, '1);
      vertex_queue.push_back(vtx(0, 0, 0));
      vertex_queue.push_back(vtx(-32768, -32768, -32768));
      vertex_queue.push_back(vtx(32767, 32767, 32767));
      vertex_queue.push_back(vtx(-32768, 0, -32768));
      vertex_queue.push_back(vtx(0, 0, 1));
      wait_drained();
      csr_write(vrp_pkg::CSR_MATRIX_ROW2, {16'h7fff, 16'h7fff, 16'h7fff});
      csr_write(vrp_pkg::CSR_OFFSET_Z, 48'h7fff);
      vertex_queue.push_back(vtx(32767, 32767, 32767));
      vertex_queue.push_back(vtx(-32768, -32768, -32768));
      wait_drained();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
            default: begin send_idle_pct = 27; recv_stall_pct = 27; end
         endcase
         if (phase == 0) begin
            csr_write(vrp_pkg::CSR_MATRIX_ROW0, vrp_pkg::ROW0_RESET);
            csr_write(vrp_pkg::CSR_MATRIX_ROW1, vrp_pkg::ROW1_RESET);
            csr_write(vrp_pkg::CSR_MATRIX_ROW2, vrp_pkg::ROW2_RESET);
            csr_write(vrp_pkg::CSR_OFFSET_X, '0);
            csr_write(vrp_pkg::CSR_OFFSET_Y, '0);
            csr_write(vrp_pkg::CSR_OFFSET_Z, '0);
         end else begin
            csr_write(vrp_pkg::CSR_MATRIX_ROW0, rand_row());
            csr_write(vrp_pkg::CSR_MATRIX_ROW1, rand_row());
            csr_write(vrp_pkg::CSR_MATRIX_ROW2, rand_row());
            csr_write(vrp_pkg::CSR_OFFSET_X, vrp_pkg::ROW_BITS'({$urandom(), $urandom()}));
            csr_write(vrp_pkg::CSR_OFFSET_Y, vrp_pkg::ROW_BITS'({$urandom(), $urandom()}));
            csr_write(vrp_pkg::CSR_OFFSET_Z,
                      vrp_pkg::ROW_BITS'($urandom_range(4000) - 2000));
         end
         load_random(PHASE_ITEMS);
         wait_drained();
      end

      $display("%0d vertices sent, %0d results checked, %0d behind the camera",
               vertices_sent, screens_seen, behind_seen);
      $display("covered reset, extreme and random matrices under four flow-control mixes");
      if (error_count == 0) begin
         $display("[vertex_rotate_project] OK");
      end else begin
         $display("[vertex_rotate_project] ERROR");
      end
      $finish;
   end
endmodule
